// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the prefetcher RTL.
// Both expect signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define PSP_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/psp_pkg.sv -----
// Shared types and constants of the PC stride prefetcher.
// No dependencies; the interface and module files refer to it by scoped names.
package psp_pkg;

	localparam int TableEntries = 16;
	localparam int MaxDegree    = 8;
	localparam int QueueDepth   = 2;

	localparam int AddrW  = 64;
	localparam int ConfW  = 4;
	localparam int CfgW   = 4;
	localparam int RegIdxW = 8;
	localparam int IdxW   = (TableEntries > 1) ? $clog2(TableEntries) : 1;
	localparam int CntW   = $clog2(MaxDegree + 1);
	localparam int DegCmpW = (CntW > CfgW) ? CntW : CfgW;
	localparam int QPtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QCntW  = $clog2(QueueDepth + 1);

	// register indexes on the configuration channel
	localparam logic [RegIdxW-1:0] RegDegree    = RegIdxW'(0);
	localparam logic [RegIdxW-1:0] RegThreshold = RegIdxW'(1);
	localparam logic [RegIdxW-1:0] RegCeiling   = RegIdxW'(2);
	localparam logic [RegIdxW-1:0] RegFloor     = RegIdxW'(3);

	localparam logic [CfgW-1:0] DegreeReset    = CfgW'(2);
	localparam logic [CfgW-1:0] ThresholdReset = CfgW'(2);
	localparam logic [CfgW-1:0] CeilingReset   = CfgW'(3);
	localparam logic [CfgW-1:0] FloorReset     = CfgW'(0);

	typedef struct packed {
		logic [CfgW-1:0] degree;
		logic [CfgW-1:0] threshold;
		logic [CfgW-1:0] ceiling;
		logic [CfgW-1:0] floor;
	} cfg_t;

	// one run of prefetches: base + stride*k, k = 1..count
	typedef struct packed {
		logic [AddrW-1:0] base;
		logic [AddrW-1:0] stride;
		logic [CntW-1:0]  count;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} head_t;

endpackage

// ----- rtl/psp_intf.sv -----
// Channel interfaces of the PC stride prefetcher: access in, prefetch out, config writes.
// Depends on psp_pkg for widths.
interface psp_access_if;
	logic                        valid;
	logic                        ready;
	logic [psp_pkg::AddrW-1:0]   access_pc;
	logic [psp_pkg::AddrW-1:0]   access_addr;
	modport source (output valid, access_pc, access_addr, input ready);
	modport sink (input valid, access_pc, access_addr, output ready);
endinterface

interface psp_prefetch_if;
	logic                        valid;
	logic                        ready;
	logic [psp_pkg::AddrW-1:0]   prefetch_addr;
	logic                        last_of_run;
	modport source (output valid, prefetch_addr, last_of_run, input ready);
	modport sink (input valid, prefetch_addr, last_of_run, output ready);
endinterface

interface psp_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [psp_pkg::RegIdxW-1:0] index;
	logic [psp_pkg::CfgW-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/psp_front.sv -----
// Front end: accepts accesses, searches the PC-keyed table, updates or allocates the
// entry and hands confident hits to the job queue. Depends on psp_pkg.
module psp_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      acc_valid,
	output logic                      acc_ready,
	input  logic [psp_pkg::AddrW-1:0] acc_pc,
	input  logic [psp_pkg::AddrW-1:0] acc_addr,
	input  psp_pkg::cfg_t             cfg,
	input  logic                      q_full,
	output psp_pkg::push_t            push
);

	// table storage
	logic                      valid_q  [psp_pkg::TableEntries];
	logic [psp_pkg::AddrW-1:0] tag_q    [psp_pkg::TableEntries];
	logic [psp_pkg::AddrW-1:0] last_q   [psp_pkg::TableEntries];
	logic [psp_pkg::AddrW-1:0] stride_q [psp_pkg::TableEntries];
	logic [psp_pkg::ConfW-1:0] conf_q   [psp_pkg::TableEntries];
	logic [psp_pkg::IdxW-1:0]  oldest_q;

	// lookup stage
	logic                      v_s1;
	logic [psp_pkg::AddrW-1:0] pc_s1;
	logic [psp_pkg::AddrW-1:0] addr_s1;
	logic                      hit;
	logic [psp_pkg::IdxW-1:0]  hit_idx;

	// update stage
	logic                      v_s2;
	logic                      hit_s2;
	logic [psp_pkg::IdxW-1:0]  idx_s2;
	logic [psp_pkg::AddrW-1:0] pc_s2;
	logic [psp_pkg::AddrW-1:0] addr_s2;

	logic                      s2_done;
	logic [psp_pkg::AddrW-1:0] ent_last;
	logic [psp_pkg::AddrW-1:0] ent_stride;
	logic [psp_pkg::ConfW-1:0] ent_conf;
	logic [psp_pkg::AddrW-1:0] diff;
	logic                      seq;
	logic [psp_pkg::ConfW:0]   conf_inc_w;
	logic [psp_pkg::ConfW-1:0] conf_inc;
	logic [psp_pkg::ConfW-1:0] conf_dec;
	logic [psp_pkg::ConfW-1:0] conf_new;
	logic [psp_pkg::DegCmpW-1:0] deg_ext;
	logic [psp_pkg::CntW-1:0]  deg_sat;

	assign acc_ready = !v_s1 && (!v_s2 || !q_full);
	assign s2_done   = v_s2 && !q_full;

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		// descending scan so the lowest matching slot wins
		for (int i = psp_pkg::TableEntries - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == pc_s1) begin
				hit     = 1'b1;
				hit_idx = psp_pkg::IdxW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc_valid && acc_ready;
			v_s2 <= v_s1 || (v_s2 && !s2_done);
		end
	end

	always_ff @(posedge clk) begin
		if (acc_valid && acc_ready) begin
			pc_s1   <= acc_pc;
			addr_s1 <= acc_addr;
		end
		if (v_s1) begin
			hit_s2  <= hit;
			idx_s2  <= hit_idx;
			pc_s2   <= pc_s1;
			addr_s2 <= addr_s1;
		end
	end

	assign ent_last   = last_q[idx_s2];
	assign ent_stride = stride_q[idx_s2];
	assign ent_conf   = conf_q[idx_s2];
	assign diff       = addr_s2 - ent_last;
	// last + stride == addr, taken modulo 2^64
	assign seq        = (diff == ent_stride);

	always_comb begin
		conf_inc_w = {1'b0, ent_conf} + (psp_pkg::ConfW+1)'(1);
		conf_inc   = (conf_inc_w > {1'b0, cfg.ceiling}) ? cfg.ceiling
			: conf_inc_w[psp_pkg::ConfW-1:0];
		conf_dec   = (ent_conf == '0 || (ent_conf - psp_pkg::ConfW'(1)) < cfg.floor)
			? cfg.floor : ent_conf - psp_pkg::ConfW'(1);
		priority if (seq) begin
			conf_new = conf_inc;
		end else if (diff != '0) begin
			conf_new = conf_dec;
		end else begin
			conf_new = ent_conf;
		end
		deg_ext = psp_pkg::DegCmpW'(cfg.degree);
		deg_sat = (deg_ext > psp_pkg::DegCmpW'(psp_pkg::MaxDegree))
			? psp_pkg::CntW'(psp_pkg::MaxDegree) : psp_pkg::CntW'(deg_ext);
	end

	always_comb begin
		push.valid      = s2_done && hit_s2 && seq && (ent_conf >= cfg.threshold)
			&& (deg_sat != '0);
		push.job.base   = addr_s2;
		push.job.stride = ent_stride;
		push.job.count  = deg_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psp_pkg::TableEntries; i++) begin
				valid_q[i] <= 1'b0;
			end
			oldest_q <= '0;
		end else if (s2_done && !hit_s2) begin
			valid_q[oldest_q] <= 1'b1;
			oldest_q <= (oldest_q == psp_pkg::IdxW'(psp_pkg::TableEntries - 1))
				? '0 : oldest_q + psp_pkg::IdxW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_done) begin
			if (hit_s2) begin
				if (diff != '0) begin
					stride_q[idx_s2] <= diff;
				end
				last_q[idx_s2] <= addr_s2;
				conf_q[idx_s2] <= conf_new;
			end else begin
				tag_q[oldest_q]    <= pc_s2;
				last_q[oldest_q]   <= addr_s2;
				stride_q[oldest_q] <= '0;
				conf_q[oldest_q]   <= '0;
			end
		end
	end

endmodule

// ----- rtl/psp_job_queue.sv -----
// Small FIFO of prefetch runs between the front end and the issue stage.
// Depends on psp_pkg.
module psp_job_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  psp_pkg::push_t push,
	output logic           full,
	output psp_pkg::head_t head,
	input  logic           pop
);

	psp_pkg::job_t              slot_q [psp_pkg::QueueDepth];
	logic [psp_pkg::QPtrW-1:0]  wr_ptr_q;
	logic [psp_pkg::QPtrW-1:0]  rd_ptr_q;
	logic [psp_pkg::QCntW-1:0]  count_q;
	logic                       do_push;
	logic                       do_pop;

	assign full       = (count_q == psp_pkg::QCntW'(psp_pkg::QueueDepth));
	assign head.valid = (count_q != '0);
	assign head.job   = slot_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == psp_pkg::QPtrW'(psp_pkg::QueueDepth - 1))
					? '0 : wr_ptr_q + psp_pkg::QPtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == psp_pkg::QPtrW'(psp_pkg::QueueDepth - 1))
					? '0 : rd_ptr_q + psp_pkg::QPtrW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + psp_pkg::QCntW'(1);
				2'b01:   count_q <= count_q - psp_pkg::QCntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.job;
		end
	end

endmodule

// ----- rtl/psp_issue.sv -----
// Back end: walks one prefetch run at a time into an output register, one address per cycle while not stalled.
// Depends on psp_pkg.
module psp_issue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  psp_pkg::head_t            head,
	output logic                      pop,
	output logic                      pf_valid,
	input  logic                      pf_ready,
	output logic [psp_pkg::AddrW-1:0] pf_addr,
	output logic                      pf_last
);

	logic                      active_q;
	logic [psp_pkg::AddrW-1:0] next_q;
	logic [psp_pkg::AddrW-1:0] stride_q;
	logic [psp_pkg::CntW-1:0]  remain_q;
	logic                      out_valid_q;
	logic [psp_pkg::AddrW-1:0] out_addr_q;
	logic                      out_last_q;
	logic                      load;

	assign pop      = !active_q && head.valid;
	assign load     = active_q && (!out_valid_q || pf_ready);
	assign pf_valid = out_valid_q;
	assign pf_addr  = out_addr_q;
	assign pf_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
			end else if (load && remain_q == psp_pkg::CntW'(1)) begin
				active_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pf_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			next_q   <= head.job.base + head.job.stride;
			stride_q <= head.job.stride;
			remain_q <= head.job.count;
		end else if (load) begin
			next_q   <= next_q + stride_q;
			remain_q <= remain_q - psp_pkg::CntW'(1);
		end
		if (load) begin
			out_addr_q <= next_q;
			out_last_q <= (remain_q == psp_pkg::CntW'(1));
		end
	end

endmodule

// ----- rtl/pc_stride_prefetcher.sv -----
// PC-indexed stride prefetcher, top level. Uses psp_pkg, psp_intf, psp_front,
// psp_job_queue, psp_issue and assert_macros.svh.
// access (sink): one memory access per item, access_pc is the table key.
// prefetch (source): predicted addresses, last_of_run marks the end of one access's run.
// cfg (sink): register writes, index 0 degree, 1 threshold, 2 ceiling, 3 floor; always ready.
// The front end searches the 16 tags in its lookup stage, then reads, updates or
// allocates the entry in its update stage; it takes no new access while one is in
// the lookup stage or while the update stage waits on a full queue. A confident hit
// pushes a run into a two-entry queue; the issue stage puts out one address per cycle
// while the receiver is ready and pops the next run only after the current run ends.
// Reset empties the table and queue and loads the register defaults; no sweep is needed.
// A stalled prefetch receiver holds the output register; the queue fills, and then
// the front end stops taking accesses until room frees up.
`include "assert_macros.svh"

module pc_stride_prefetcher (
	input logic              clk,
	input logic              arst_n,
	psp_access_if.sink       access,
	psp_prefetch_if.source   prefetch,
	psp_cfg_if.sink          cfg
);

	psp_pkg::cfg_t  cfg_q;
	psp_pkg::push_t push;
	psp_pkg::head_t head;
	logic           q_full;
	logic           pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.degree    <= psp_pkg::DegreeReset;
			cfg_q.threshold <= psp_pkg::ThresholdReset;
			cfg_q.ceiling   <= psp_pkg::CeilingReset;
			cfg_q.floor     <= psp_pkg::FloorReset;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				psp_pkg::RegDegree:    cfg_q.degree    <= cfg.data;
				psp_pkg::RegThreshold: cfg_q.threshold <= cfg.data;
				psp_pkg::RegCeiling:   cfg_q.ceiling   <= cfg.data;
				psp_pkg::RegFloor:     cfg_q.floor     <= cfg.data;
				default:               cfg_q           <= cfg_q;
			endcase
		end
	end

	psp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (access.valid),
		.acc_ready (access.ready),
		.acc_pc    (access.access_pc),
		.acc_addr  (access.access_addr),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push)
	);

	psp_job_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	psp_issue u_issue (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.pf_valid (prefetch.valid),
		.pf_ready (prefetch.ready),
		.pf_addr  (prefetch.prefetch_addr),
		.pf_last  (prefetch.last_of_run)
	);

	`PSP_ASSERT_ALWAYS(a_no_push_when_full, !(push.valid && q_full))
	`PSP_ASSERT_ALWAYS(a_run_not_empty, !push.valid || push.job.count != '0)
	`PSP_ASSERT_NEXT(a_two_cycle_front, access.valid && access.ready, !access.ready)

endmodule
